[rtl/core/adsr_pkg.sv]
// Shared constants, codes and helpers for the multi-voice ADSR envelope.
`timescale 1ns / 1ps

package adsr_pkg;

    // Field widths
    localparam int LEVEL_W = 21;
    localparam int STAGE_W = 3;
    localparam int OP_W    = 2;
    localparam int VOICE_W = 6;
    localparam int CFG_W   = 2;
    localparam int FRAC_W  = 20;

    localparam int VOICES_DEFAULT = 64;

    // Level constants, 1.0 = 2^20
    localparam logic [LEVEL_W-1:0] LEVEL_ONE   = 21'd1048576;
    localparam logic [LEVEL_W-1:0] ATTACK_DONE = 21'd1038091;
    localparam logic [LEVEL_W-1:0] NEAR_LIMIT  = 21'd1049;

    // Envelope stages
    localparam logic [STAGE_W-1:0] ST_IDLE    = 3'd0;
    localparam logic [STAGE_W-1:0] ST_ATTACK  = 3'd1;
    localparam logic [STAGE_W-1:0] ST_DECAY   = 3'd2;
    localparam logic [STAGE_W-1:0] ST_SUSTAIN = 3'd3;
    localparam logic [STAGE_W-1:0] ST_RELEASE = 3'd4;

    // Operations carried on the input beat
    localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
    localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd1;
    localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_W-1:0] CFG_ATTACK  = 2'd0;
    localparam logic [CFG_W-1:0] CFG_DECAY   = 2'd1;
    localparam logic [CFG_W-1:0] CFG_RELEASE = 2'd2;
    localparam logic [CFG_W-1:0] CFG_SUSTAIN = 2'd3;

    // One stored voice entry
    typedef struct packed {
        logic [STAGE_W-1:0] stage;
        logic [LEVEL_W-1:0] level;
    } voice_state_t;

    localparam int STATE_W = STAGE_W + LEVEL_W;

    // Values above 1.0 behave as 1.0.
    function automatic logic [LEVEL_W-1:0] clamp_one(input logic [LEVEL_W-1:0] v);
        clamp_one = (v > LEVEL_ONE) ? LEVEL_ONE : v;
    endfunction

endpackage

[rtl/core/adsr_envelope_voices_top.sv]
// Top level of the multi-voice ADSR envelope: voice store, tick arithmetic and stream ports.
`timescale 1ns / 1ps

// Channel     Direction  Ports                        Contents
// s_ (items)  in         s_tvalid s_tready s_tdata    tdata: voice; tuser: operation
//                        s_tuser
// m_ (result) out        m_tvalid m_tready m_tdata    tdata: level, stage
// cfg         in         cfg_wr_en cfg_index          one register write per asserted cycle
//                        cfg_wdata
//
// One beat is accepted in every cycle while the result side is not stalled, including beats
// that address the same voice as the beat just before. The result beat is registered in the
// compute stage and then in the result register before it is offered on m_. The rate is
// set by the single read-modify-write of the voice RAM, which reads at acceptance and
// writes as the beat moves on, with a one-entry bypass covering the write still in flight.
// Reset clears every voice at once through a valid flip-flop per voice; there is no sweep.
// When the result register is full and not taken, the compute stage holds and s_tready falls.

module adsr_envelope_voices_top #(
    parameter int VOICES = adsr_pkg::VOICES_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [5:0] voice, [7:6] zero
    input  logic [adsr_pkg::OP_W-1:0]   s_tuser,   // [1:0] operation

    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,   // [20:0] level, [23:21] stage

    input  logic                        cfg_wr_en,
    input  logic [adsr_pkg::CFG_W-1:0]  cfg_index,
    input  logic [adsr_pkg::LEVEL_W-1:0] cfg_wdata
);

    localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int LW = adsr_pkg::LEVEL_W;
    localparam int SW = adsr_pkg::STAGE_W;

    // Configuration registers, kept as written; clamping is applied where they are used.
    logic [LW-1:0] attack_coeff_reg;
    logic [LW-1:0] decay_coeff_reg;
    logic [LW-1:0] release_coeff_reg;
    logic [LW-1:0] sustain_level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_coeff_reg  <= adsr_pkg::LEVEL_ONE;
            decay_coeff_reg   <= adsr_pkg::LEVEL_ONE;
            release_coeff_reg <= adsr_pkg::LEVEL_ONE;
            sustain_level_reg <= adsr_pkg::LEVEL_ONE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                adsr_pkg::CFG_ATTACK:  attack_coeff_reg  <= cfg_wdata;
                adsr_pkg::CFG_DECAY:   decay_coeff_reg   <= cfg_wdata;
                adsr_pkg::CFG_RELEASE: release_coeff_reg <= cfg_wdata;
                adsr_pkg::CFG_SUSTAIN: sustain_level_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input decode. A voice at or beyond VOICES touches nothing and reports idle.
    logic [adsr_pkg::VOICE_W-1:0] in_voice;
    logic [AW-1:0]                in_addr;
    logic                         in_range;
    logic                         in_accept;

    assign in_voice  = s_tdata[adsr_pkg::VOICE_W-1:0];
    assign in_addr   = AW'(in_voice);
    assign in_range  = 32'(in_voice) < 32'(VOICES);
    assign in_accept = s_tvalid && s_tready;

    // Compute stage registers
    logic                       s1_valid_reg;
    logic [adsr_pkg::OP_W-1:0]  s1_op_reg;
    logic [AW-1:0]              s1_addr_reg;
    logic                       s1_range_reg;
    logic                       s1_written_reg;
    logic                       s1_fwd_reg;
    adsr_pkg::voice_state_t     s1_fwd_state_reg;

    // Result register
    logic          m_valid_reg;
    logic [LW-1:0] m_level_reg;
    logic [SW-1:0] m_stage_reg;

    logic s1_advance;
    assign s1_advance = !m_valid_reg || m_tready;
    assign s_tready   = !s1_valid_reg || s1_advance;

    // Per-voice valid bits stand in for clearing the RAM at reset.
    logic [VOICES-1:0] written_reg;

    // Voice store
    logic                   wr_en;
    adsr_pkg::voice_state_t wr_state;
    logic [adsr_pkg::STATE_W-1:0] rd_word;

    adsr_ram #(
        .WIDTH (adsr_pkg::STATE_W),
        .DEPTH (VOICES)
    ) u_voice_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_state),
        .rd_en   (in_accept),
        .rd_addr (in_addr),
        .rd_data (rd_word)
    );

    // Current voice state: the bypassed write wins, then the RAM if the entry was ever
    // written, otherwise the reset state.
    adsr_pkg::voice_state_t cur;

    always_comb begin
        if (s1_fwd_reg) begin
            cur = s1_fwd_state_reg;
        end else if (s1_written_reg) begin
            cur = adsr_pkg::voice_state_t'(rd_word);
        end else begin
            cur.stage = adsr_pkg::ST_IDLE;
            cur.level = '0;
        end
    end

    // Operand selection for the single shared multiplier.
    logic [LW-1:0]   sus;
    logic [LW-1:0]   mul_dist;
    logic [LW-1:0]   mul_coeff;
    logic [2*LW-1:0] product;
    logic [LW-1:0]   step_raw;
    logic [LW-1:0]   step;

    assign sus = adsr_pkg::clamp_one(sustain_level_reg);

    always_comb begin
        mul_dist  = '0;
        mul_coeff = '0;
        case (cur.stage)
            adsr_pkg::ST_ATTACK: begin
                mul_dist  = (cur.level < adsr_pkg::LEVEL_ONE) ?
                            adsr_pkg::LEVEL_ONE - cur.level : '0;
                mul_coeff = adsr_pkg::clamp_one(attack_coeff_reg);
            end
            adsr_pkg::ST_DECAY: begin
                mul_dist  = (cur.level > sus) ? cur.level - sus : sus - cur.level;
                mul_coeff = adsr_pkg::clamp_one(decay_coeff_reg);
            end
            adsr_pkg::ST_RELEASE: begin
                mul_dist  = cur.level;
                mul_coeff = adsr_pkg::clamp_one(release_coeff_reg);
            end
            default: begin
                mul_dist  = '0;
                mul_coeff = '0;
            end
        endcase
    end

    // The step is the truncated fraction of the distance, but never less than one LSB
    // while any distance remains.
    assign product  = mul_dist * mul_coeff;
    assign step_raw = product[LW+adsr_pkg::FRAC_W-1:adsr_pkg::FRAC_W];
    assign step     = (mul_dist != '0 && step_raw == '0) ? LW'(1) : step_raw;

    // Tick outcome and the effect of the operation.
    logic [LW:0]            sum;
    logic [LW-1:0]          moved;
    logic [LW-1:0]          dist_after;
    adsr_pkg::voice_state_t ticked;
    adsr_pkg::voice_state_t nxt;

    always_comb begin
        sum        = '0;
        moved      = '0;
        dist_after = '0;
        ticked     = cur;
        case (cur.stage)
            adsr_pkg::ST_ATTACK: begin
                sum = {1'b0, cur.level} + {1'b0, step};
                if (sum >= {1'b0, adsr_pkg::ATTACK_DONE}) begin
                    ticked.level = adsr_pkg::LEVEL_ONE;
                    ticked.stage = adsr_pkg::ST_DECAY;
                end else begin
                    ticked.level = sum[LW-1:0];
                end
            end
            adsr_pkg::ST_DECAY: begin
                // Decay approaches sustain from either side.
                moved = (cur.level > sus) ? cur.level - step : cur.level + step;
                dist_after = (moved > sus) ? moved - sus : sus - moved;
                if (dist_after < adsr_pkg::NEAR_LIMIT) begin
                    ticked.level = sus;
                    ticked.stage = adsr_pkg::ST_SUSTAIN;
                end else begin
                    ticked.level = moved;
                end
            end
            adsr_pkg::ST_SUSTAIN: begin
                ticked.level = sus;
            end
            adsr_pkg::ST_RELEASE: begin
                moved = cur.level - step;
                if (moved < adsr_pkg::NEAR_LIMIT) begin
                    ticked.level = '0;
                    ticked.stage = adsr_pkg::ST_IDLE;
                end else begin
                    ticked.level = moved;
                end
            end
            default: begin
                ticked.level = '0;
                ticked.stage = adsr_pkg::ST_IDLE;
            end
        endcase

        nxt = cur;
        case (s1_op_reg)
            adsr_pkg::OP_TICK:     nxt = ticked;
            adsr_pkg::OP_NOTE_ON:  nxt.stage = adsr_pkg::ST_ATTACK;
            adsr_pkg::OP_NOTE_OFF: nxt.stage = adsr_pkg::ST_RELEASE;
            adsr_pkg::OP_QUERY:    nxt = cur;
            default:               nxt = cur;
        endcase
    end

    assign wr_en    = s1_valid_reg && s1_advance && s1_range_reg;
    assign wr_state = nxt;

    // Compute stage control and bypass capture.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_op_reg        <= s_tuser;
            s1_addr_reg      <= in_addr;
            s1_range_reg     <= in_range;
            s1_written_reg   <= in_range && written_reg[in_addr];
            s1_fwd_reg       <= wr_en && (s1_addr_reg == in_addr);
            s1_fwd_state_reg <= nxt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else if (wr_en) begin
            written_reg[s1_addr_reg] <= 1'b1;
        end
    end

    // Result register: parts the compute stage from the downstream side.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance && s1_valid_reg) begin
            if (s1_range_reg) begin
                m_level_reg <= nxt.level;
                m_stage_reg <= nxt.stage;
            end else begin
                m_level_reg <= '0;
                m_stage_reg <= adsr_pkg::ST_IDLE;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_stage_reg, m_level_reg};

    // The stage reported is always one of the five defined stages.
    a_stage_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_stage_reg <= adsr_pkg::ST_RELEASE))
        else $error("result stage outside the defined stages");

    // No level ever exceeds 1.0.
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_level_reg <= adsr_pkg::LEVEL_ONE))
        else $error("result level above 1.0");

    // An idle voice is silent.
    a_idle_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_stage_reg == adsr_pkg::ST_IDLE) |-> (m_level_reg == '0))
        else $error("idle voice with non-zero level");

    // Input back-pressure only arises from a full, untaken result register.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s1_valid_reg && m_valid_reg && !m_tready))
        else $error("input stalled without a downstream stall");

    // A stalled compute stage must not write the voice store.
    a_no_write_in_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !wr_en)
        else $error("voice store written while the result is stalled");

endmodule

[rtl/core/adsr_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module adsr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
